[src/rsa_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RSA exponentiation package
// Shared widths, register indexes and reset values.
// ---------------------------------------------------------------------------
package rsa_pkg;
	localparam int unsigned MOD_BITS_DEF = 32;
	localparam int unsigned REG_W = 32;
	localparam int unsigned IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_MODULUS = 2'd0;
	localparam logic [IDX_W-1:0] REG_PUB_EXP = 2'd1;
	localparam logic [IDX_W-1:0] REG_PRIV_EXP = 2'd2;

	localparam logic [REG_W-1:0] RST_MODULUS = 32'd3233;
	localparam logic [REG_W-1:0] RST_PUB_EXP = 32'd17;
	localparam logic [REG_W-1:0] RST_PRIV_EXP = 32'd2753;
endpackage

[src/rsa_modular_exponentiation.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RSA modular exponentiation
// value^e mod n (encrypt) or value^d mod n (decrypt), square and multiply.
// ---------------------------------------------------------------------------
// channel  | signals                          | direction
// input    | valid, stall, req_type, value    | in (stall out)
// output   | out_valid, out_stall, result     | out (stall in)
// config   | wr_en, wr_index, wr_data         | in
//
// Each modular product runs on the single shared bit-serial multiplier. A
// word needs one product to reduce the value, one square per exponent bit
// up to the highest set bit and one multiply per set bit, plus the ST_IDLE
// state to accept and the ST_DONE state to hand over the result. Reset loads
// the default key. Input is stalled while a word is in work, not while its
// result waits; a stalled result holds.
// ---------------------------------------------------------------------------
module rsa_modular_exponentiation import rsa_pkg::*; #(
	parameter int unsigned MOD_BITS = MOD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	output logic              stall,
	input  logic              req_type,
	input  logic [REG_W-1:0]  value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [REG_W-1:0]  result,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [REG_W-1:0]  wr_data
);
	localparam int unsigned W = MOD_BITS;
	localparam int unsigned CW = $clog2(W + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_RED, ST_MUL, ST_SQR, ST_DONE
	} state_t;

	state_t        state_q;
	logic [W-1:0]  mod_q;
	logic [W-1:0]  pub_q;
	logic [W-1:0]  priv_q;
	logic [W-1:0]  base_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  exp_q;
	logic [CW-1:0] bits_q;
	logic          zero_q;
	logic          pend_q;
	logic [REG_W-1:0] result_q;

	logic          mstart;
	logic [W-1:0]  ma;
	logic [W-1:0]  mb;
	logic          mdone;
	logic [W-1:0]  mprod;
	logic [W-1:0]  sel_exp;
	logic          accept;

	function automatic logic [W-1:0] fit(input logic [REG_W-1:0] x);
		logic [W+REG_W-1:0] t;
		t = {{W{1'b0}}, x};
		return t[W-1:0];
	endfunction

	function automatic logic [REG_W-1:0] widen(input logic [W-1:0] x);
		logic [W+REG_W-1:0] t;
		t = {{REG_W{1'b0}}, x};
		return t[REG_W-1:0];
	endfunction

	assign accept = valid && !stall;
	assign stall = (state_q != ST_IDLE);
	assign sel_exp = req_type ? priv_q : pub_q;

	rsa_mulmod #(.W(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mstart), .a(ma), .b(mb),
		.n(mod_q), .done(mdone), .prod(mprod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= fit(RST_MODULUS);
			pub_q <= fit(RST_PUB_EXP);
			priv_q <= fit(RST_PRIV_EXP);
		end else if (wr_en) begin
			case (wr_index)
				REG_MODULUS:  mod_q <= fit(wr_data);
				REG_PUB_EXP:  pub_q <= fit(wr_data);
				REG_PRIV_EXP: priv_q <= fit(wr_data);
				default: ;
			endcase
		end
	end

	// Multiplier operands by phase; reduction of the value is 1*value mod n,
	// with the raw value as the serial operand so it may exceed the modulus.
	always_comb begin
		mstart = 1'b0;
		ma = base_q;
		mb = base_q;
		case (state_q)
			ST_RED: begin
				ma = W'(1);
				mb = base_q;
				mstart = !pend_q;
			end
			ST_MUL: begin
				ma = acc_q;
				mb = base_q;
				mstart = !pend_q;
			end
			ST_SQR: begin
				mstart = !pend_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (mstart)
				pend_q <= 1'b1;
			else if (mdone)
				pend_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_RED;
				end
				ST_RED: begin
					if (mdone) begin
						if (zero_q)
							state_q <= ST_DONE;
						else if (exp_q[0])
							state_q <= ST_MUL;
						else
							state_q <= ST_SQR;
					end
				end
				ST_MUL: begin
					if (mdone)
						state_q <= ST_SQR;
				end
				ST_SQR: begin
					if (mdone) begin
						if (bits_q == CW'(1) || exp_q[W-1:1] == '0)
							state_q <= ST_DONE;
						else if (exp_q[1])
							state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_valid && !out_stall && state_q != ST_DONE)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					base_q <= fit(value);
					exp_q <= sel_exp;
					zero_q <= (sel_exp == '0);
					bits_q <= CW'(W);
				end
			end
			ST_RED: begin
				if (mdone) begin
					base_q <= mprod;
					// 1 mod n: zero only when n is one.
					acc_q <= (mod_q == W'(1)) ? '0 : W'(1);
				end
			end
			ST_MUL: begin
				if (mdone)
					acc_q <= mprod;
			end
			ST_SQR: begin
				if (mdone) begin
					base_q <= mprod;
					exp_q <= {1'b0, exp_q[W-1:1]};
					bits_q <= bits_q - 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_valid || !out_stall)
					result_q <= zero_q ? REG_W'(1) : widen(acc_q);
			end
			default: ;
		endcase
	end

	assign result = result_q;
endmodule

[src/rsa_mulmod.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RSA modular multiplier
// Bit-serial shift-and-add product a*b mod n, one bit of b per cycle,
// most significant bit first. A zero modulus means 2^W (plain wrap).
// ---------------------------------------------------------------------------
module rsa_mulmod #(
	parameter int unsigned W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] n,
	output logic         done,
	output logic [W-1:0] prod
);
	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  acc_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic          nz;
	logic [W:0]    dbl;
	logic [W:0]    dbl_red;
	logic [W-1:0]  acc1;
	logic [W:0]    sum;
	logic [W:0]    sum_red;
	logic [W-1:0]  acc2;

	assign nz = (n == '0);

	// Double, then conditionally add; each sum is below 2n, so one subtract reduces it.
	always_comb begin
		dbl = {acc_q, 1'b0};
		dbl_red = dbl - {1'b0, n};
		if (nz)
			acc1 = dbl[W-1:0];
		else if (dbl >= {1'b0, n})
			acc1 = dbl_red[W-1:0];
		else
			acc1 = dbl[W-1:0];
		sum = {1'b0, acc1} + {1'b0, a_q};
		sum_red = sum - {1'b0, n};
		if (!b_q[W-1])
			acc2 = acc1;
		else if (nz)
			acc2 = sum[W-1:0];
		else if (sum >= {1'b0, n})
			acc2 = sum_red[W-1:0];
		else
			acc2 = sum[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc2;
			b_q <= {b_q[W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
